// File: rtl/gbf_pkg.sv
package gbf_pkg;

  // item modes
  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;
  localparam logic [1:0] MODE_FIND   = 2'd3;

  // parent code of a search root
  localparam logic [6:0] NO_PARENT = 7'h7f;

  typedef struct packed {
    logic [1:0] mode;
    logic [5:0] end_a;
    logic [5:0] end_b;
  } in_item_t;

  typedef struct packed {
    logic [5:0] bridge_parent;
    logic [5:0] bridge_child;
    logic       is_bridge;
    logic       last;
  } out_item_t;

  // one search frame held on the stack
  typedef struct packed {
    logic [5:0] vtx;
    logic [6:0] idx;
    logic [6:0] low;
    logic [6:0] disc;
    logic [6:0] par;
  } frame_t;

  // request from the search sequencer to the result stage
  typedef struct packed {
    logic       valid;
    logic       fin;
    logic [5:0] parent;
    logic [5:0] child;
  } res_req_t;

endpackage

// File: rtl/gbf_ram.sv
module gbf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

// File: rtl/gbf_result.sv
module gbf_result import gbf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  res_req_t  req,
  output logic      ready,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r, out_item_nxt;
  logic      pend_v_r, pend_v_nxt;
  logic [5:0] pend_p_r, pend_p_nxt;
  logic [5:0] pend_c_r, pend_c_nxt;
  logic      out_free;
  logic      load;

  assign out_free = !out_valid_r || !out_stall;
  assign ready    = out_free || (!req.fin && !pend_v_r);

  // one bridge is held back until it is known whether it is the last
  always_comb begin
    load          = 1'b0;
    out_item_nxt  = out_item_r;
    pend_v_nxt    = pend_v_r;
    pend_p_nxt    = pend_p_r;
    pend_c_nxt    = pend_c_r;
    if (req.valid && ready) begin
      if (req.fin) begin
        load       = 1'b1;
        pend_v_nxt = 1'b0;
        if (pend_v_r) begin
          out_item_nxt = '{bridge_parent: pend_p_r, bridge_child: pend_c_r,
                           is_bridge: 1'b1, last: 1'b1};
        end else begin
          out_item_nxt = '{bridge_parent: 6'd0, bridge_child: 6'd0,
                           is_bridge: 1'b0, last: 1'b1};
        end
      end else begin
        if (pend_v_r) begin
          load         = 1'b1;
          out_item_nxt = '{bridge_parent: pend_p_r, bridge_child: pend_c_r,
                           is_bridge: 1'b1, last: 1'b0};
        end
        pend_v_nxt = 1'b1;
        pend_p_nxt = req.parent;
        pend_c_nxt = req.child;
      end
    end
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_v_r    <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      pend_v_r    <= pend_v_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
    pend_p_r   <= pend_p_nxt;
    pend_c_r   <= pend_c_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// File: rtl/gbf_core.sv
module gbf_core import gbf_pkg::*; #(
  parameter int MAX_VERTICES = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  in_item_t in_item,
  output logic     in_stall,
  input  logic [6:0] n_eff,
  output res_req_t res_req,
  input  logic     res_ready
);

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int FW = $bits(frame_t);
  localparam logic [6:0] MAX_V7 = 7'(MAX_VERTICES);
  localparam logic [MAX_VERTICES-1:0] ONE = {{(MAX_VERTICES-1){1'b0}}, 1'b1};

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_EA_WR = 10'b0000000010,
    S_EB_WR = 10'b0000000100,
    S_ROOT  = 10'b0000001000,
    S_LOAD  = 10'b0000010000,
    S_SCAN  = 10'b0000100000,
    S_BACK  = 10'b0001000000,
    S_POP   = 10'b0010000000,
    S_EMIT  = 10'b0100000000,
    S_FIN   = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  logic [MAX_VERTICES-1:0] adj_vld_r, adj_vld_nxt;
  logic [MAX_VERTICES-1:0] vis_r, vis_nxt;
  logic [MAX_VERTICES-1:0] crow_r, crow_nxt;
  logic [6:0] r_r, r_nxt;
  logic [6:0] time_r, time_nxt;
  logic [6:0] sp_r, sp_nxt;
  logic [5:0] cu_r, cu_nxt;
  logic [6:0] cidx_r, cidx_nxt;
  logic [6:0] clow_r, clow_nxt;
  logic [6:0] cdisc_r, cdisc_nxt;
  logic [6:0] cpar_r, cpar_nxt;
  logic [5:0] chu_r, chu_nxt;
  logic [6:0] chlow_r, chlow_nxt;
  logic       br_r, br_nxt;
  logic [5:0] brp_r, brp_nxt;
  logic [5:0] a_r, a_nxt;
  logic [5:0] b_r, b_nxt;
  logic       set_r, set_nxt;

  logic                    adj_wr_en, adj_rd_en;
  logic [VW-1:0]           adj_wr_addr, adj_rd_addr;
  logic [MAX_VERTICES-1:0] adj_wr_data, adj_rd_data;
  logic                    disc_wr_en, disc_rd_en;
  logic [VW-1:0]           disc_wr_addr, disc_rd_addr;
  logic [6:0]              disc_wr_data, disc_rd_data;
  logic                    stk_wr_en, stk_rd_en;
  logic [VW-1:0]           stk_wr_addr, stk_rd_addr;
  logic [FW-1:0]           stk_wr_data, stk_rd_data;

  frame_t                  pop_f;
  logic [MAX_VERTICES-1:0] row_old;
  logic [5:0]              w;
  logic [6:0]              sp_dec;
  logic                    accept;
  logic                    edge_ok;

  assign accept   = in_valid && (state_r == S_IDLE);
  assign in_stall = (state_r != S_IDLE);
  assign pop_f    = frame_t'(stk_rd_data);
  assign w        = cidx_r[5:0];
  assign sp_dec   = sp_r - 7'd1;
  assign edge_ok  = (in_item.end_a != in_item.end_b) &&
                    ({1'b0, in_item.end_a} < MAX_V7) &&
                    ({1'b0, in_item.end_b} < MAX_V7);

  // sequencer: edge updates and the depth-first bridge search
  always_comb begin
    state_nxt   = state_r;
    adj_vld_nxt = adj_vld_r;
    vis_nxt     = vis_r;
    crow_nxt    = crow_r;
    r_nxt       = r_r;
    time_nxt    = time_r;
    sp_nxt      = sp_r;
    cu_nxt      = cu_r;
    cidx_nxt    = cidx_r;
    clow_nxt    = clow_r;
    cdisc_nxt   = cdisc_r;
    cpar_nxt    = cpar_r;
    chu_nxt     = chu_r;
    chlow_nxt   = chlow_r;
    br_nxt      = br_r;
    brp_nxt     = brp_r;
    a_nxt       = a_r;
    b_nxt       = b_r;
    set_nxt     = set_r;

    adj_wr_en    = 1'b0;
    adj_wr_addr  = a_r[VW-1:0];
    adj_wr_data  = '0;
    adj_rd_en    = 1'b0;
    adj_rd_addr  = cu_r[VW-1:0];
    disc_wr_en   = 1'b0;
    disc_wr_addr = w[VW-1:0];
    disc_wr_data = time_r + 7'd1;
    disc_rd_en   = 1'b0;
    disc_rd_addr = w[VW-1:0];
    stk_wr_en    = 1'b0;
    stk_wr_addr  = sp_r[VW-1:0];
    stk_wr_data  = frame_t'{vtx: cu_r, idx: cidx_r + 7'd1, low: clow_r,
                            disc: cdisc_r, par: cpar_r};
    stk_rd_en    = 1'b0;
    stk_rd_addr  = sp_dec[VW-1:0];
    res_req      = '{valid: 1'b0, fin: 1'b0, parent: brp_r, child: chu_r};
    row_old      = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          a_nxt   = in_item.end_a;
          b_nxt   = in_item.end_b;
          set_nxt = (in_item.mode == MODE_ADD);
          unique case (in_item.mode)
            MODE_ADD, MODE_REMOVE: begin
              if (edge_ok) begin
                adj_rd_en   = 1'b1;
                adj_rd_addr = in_item.end_a[VW-1:0];
                state_nxt   = S_EA_WR;
              end
            end
            MODE_CLEAR: begin
              adj_vld_nxt = '0;
            end
            MODE_FIND: begin
              vis_nxt   = '0;
              time_nxt  = 7'd0;
              sp_nxt    = 7'd0;
              r_nxt     = 7'd0;
              state_nxt = S_ROOT;
            end
            default: begin
            end
          endcase
        end
      end

      // update row a, fetch row b
      S_EA_WR: begin
        row_old     = adj_vld_r[a_r[VW-1:0]] ? adj_rd_data : '0;
        adj_wr_en   = 1'b1;
        adj_wr_addr = a_r[VW-1:0];
        adj_wr_data = set_r ? (row_old | (ONE << b_r[VW-1:0]))
                            : (row_old & ~(ONE << b_r[VW-1:0]));
        adj_vld_nxt[a_r[VW-1:0]] = 1'b1;
        adj_rd_en   = 1'b1;
        adj_rd_addr = b_r[VW-1:0];
        state_nxt   = S_EB_WR;
      end

      S_EB_WR: begin
        row_old     = adj_vld_r[b_r[VW-1:0]] ? adj_rd_data : '0;
        adj_wr_en   = 1'b1;
        adj_wr_addr = b_r[VW-1:0];
        adj_wr_data = set_r ? (row_old | (ONE << a_r[VW-1:0]))
                            : (row_old & ~(ONE << a_r[VW-1:0]));
        adj_vld_nxt[b_r[VW-1:0]] = 1'b1;
        state_nxt   = S_IDLE;
      end

      // pick the next unvisited root
      S_ROOT: begin
        if (r_r >= n_eff) begin
          state_nxt = S_FIN;
        end else if (vis_r[r_r[VW-1:0]]) begin
          r_nxt = r_r + 7'd1;
        end else begin
          time_nxt     = time_r + 7'd1;
          disc_wr_en   = 1'b1;
          disc_wr_addr = r_r[VW-1:0];
          vis_nxt[r_r[VW-1:0]] = 1'b1;
          cu_nxt    = r_r[5:0];
          cidx_nxt  = 7'd0;
          clow_nxt  = time_r + 7'd1;
          cdisc_nxt = time_r + 7'd1;
          cpar_nxt  = NO_PARENT;
          adj_rd_en   = 1'b1;
          adj_rd_addr = r_r[VW-1:0];
          state_nxt   = S_LOAD;
        end
      end

      S_LOAD: begin
        crow_nxt  = adj_vld_r[cu_r[VW-1:0]] ? adj_rd_data : '0;
        state_nxt = S_SCAN;
      end

      // one neighbour bit per cycle, paused by a back-edge test or a descent
      S_SCAN: begin
        if (cidx_r >= n_eff) begin
          if (sp_r == 7'd0) begin
            state_nxt = S_ROOT;
          end else begin
            stk_rd_en = 1'b1;
            chu_nxt   = cu_r;
            chlow_nxt = clow_r;
            state_nxt = S_POP;
          end
        end else if (!crow_r[cidx_r[VW-1:0]]) begin
          cidx_nxt = cidx_r + 7'd1;
        end else if (!vis_r[w[VW-1:0]]) begin
          // descend into w
          stk_wr_en  = 1'b1;
          sp_nxt     = sp_r + 7'd1;
          time_nxt   = time_r + 7'd1;
          disc_wr_en = 1'b1;
          vis_nxt[w[VW-1:0]] = 1'b1;
          cu_nxt    = w;
          cidx_nxt  = 7'd0;
          clow_nxt  = time_r + 7'd1;
          cdisc_nxt = time_r + 7'd1;
          cpar_nxt  = {1'b0, cu_r};
          adj_rd_en   = 1'b1;
          adj_rd_addr = w[VW-1:0];
          state_nxt   = S_LOAD;
        end else if ({1'b0, w} != cpar_r) begin
          disc_rd_en = 1'b1;
          cidx_nxt   = cidx_r + 7'd1;
          state_nxt  = S_BACK;
        end else begin
          cidx_nxt = cidx_r + 7'd1;
        end
      end

      // back edge lowers the low link
      S_BACK: begin
        if (disc_rd_data < clow_r) begin
          clow_nxt = disc_rd_data;
        end
        state_nxt = S_SCAN;
      end

      // return to the parent frame
      S_POP: begin
        sp_nxt    = sp_dec;
        cu_nxt    = pop_f.vtx;
        cidx_nxt  = pop_f.idx;
        cdisc_nxt = pop_f.disc;
        cpar_nxt  = pop_f.par;
        clow_nxt  = (chlow_r < pop_f.low) ? chlow_r : pop_f.low;
        br_nxt    = (chlow_r > pop_f.disc);
        brp_nxt   = pop_f.vtx;
        state_nxt = S_EMIT;
      end

      S_EMIT: begin
        res_req.valid = br_r;
        if (!br_r || res_ready) begin
          br_nxt    = 1'b0;
          adj_rd_en = 1'b1;
          state_nxt = S_LOAD;
        end
      end

      S_FIN: begin
        res_req.valid = 1'b1;
        res_req.fin   = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      adj_vld_r <= '0;
      vis_r     <= '0;
      r_r       <= 7'd0;
      time_r    <= 7'd0;
      sp_r      <= 7'd0;
      br_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      adj_vld_r <= adj_vld_nxt;
      vis_r     <= vis_nxt;
      r_r       <= r_nxt;
      time_r    <= time_nxt;
      sp_r      <= sp_nxt;
      br_r      <= br_nxt;
    end
  end

  // frame and operand registers
  always_ff @(posedge clk) begin
    crow_r  <= crow_nxt;
    cu_r    <= cu_nxt;
    cidx_r  <= cidx_nxt;
    clow_r  <= clow_nxt;
    cdisc_r <= cdisc_nxt;
    cpar_r  <= cpar_nxt;
    chu_r   <= chu_nxt;
    chlow_r <= chlow_nxt;
    brp_r   <= brp_nxt;
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    set_r   <= set_nxt;
  end

  // adjacency rows
  gbf_ram #(.WIDTH(MAX_VERTICES), .DEPTH(MAX_VERTICES)) u_adj_ram (
    .clk     (clk),
    .wr_en   (adj_wr_en),
    .wr_addr (adj_wr_addr),
    .wr_data (adj_wr_data),
    .rd_en   (adj_rd_en),
    .rd_addr (adj_rd_addr),
    .rd_data (adj_rd_data)
  );

  // discovery times
  gbf_ram #(.WIDTH(7), .DEPTH(MAX_VERTICES)) u_disc_ram (
    .clk     (clk),
    .wr_en   (disc_wr_en),
    .wr_addr (disc_wr_addr),
    .wr_data (disc_wr_data),
    .rd_en   (disc_rd_en),
    .rd_addr (disc_rd_addr),
    .rd_data (disc_rd_data)
  );

  // frames below the current one
  gbf_ram #(.WIDTH(FW), .DEPTH(MAX_VERTICES)) u_stack_ram (
    .clk     (clk),
    .wr_en   (stk_wr_en),
    .wr_addr (stk_wr_addr),
    .wr_data (stk_wr_data),
    .rd_en   (stk_rd_en),
    .rd_addr (stk_rd_addr),
    .rd_data (stk_rd_data)
  );

endmodule

// File: rtl/graph_bridge_finder_unit.sv
// add or remove edge: reads and rewrites row a, then row b; a self-loop or an end out of
//   range leaves the rows as they are; clear: empties every adjacency row
// find: depth-first search over the n vertices in use, with a back-edge test from each
//   end of a non-tree edge, and waits whenever the result side stalls
// one item in flight at a time, input stalled meanwhile; registered result output
// synchronous active-low reset empties every adjacency row, vertex count returns to 64
module graph_bridge_finder_unit import gbf_pkg::*; #(
  parameter int MAX_VERTICES = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  in_item_t   in_item,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_item,
  input  logic       cfg_wr_en,
  input  logic [6:0] cfg_wr_data
);

  localparam logic [6:0] MAX_V7 = 7'(MAX_VERTICES);

  logic [6:0] vertex_count_r;
  logic [6:0] n_eff;
  res_req_t   res_req;
  logic       res_ready;

  // vertex count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vertex_count_r <= 7'd64;
    end else if (cfg_wr_en) begin
      vertex_count_r <= cfg_wr_data;
    end
  end

  assign n_eff = (vertex_count_r > MAX_V7) ? MAX_V7 : vertex_count_r;

  gbf_core #(.MAX_VERTICES(MAX_VERTICES)) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .in_stall  (in_stall),
    .n_eff     (n_eff),
    .res_req   (res_req),
    .res_ready (res_ready)
  );

  gbf_result u_result (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (res_req),
    .ready     (res_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// File: dv/tb_graph_bridge_finder_unit.sv
`timescale 1ns / 100ps

module tb_graph_bridge_finder_unit;
  import gbf_pkg::*;

  // tracks the graph, predicts bridge results and checks what comes out
  class bridge_scoreboard;
    logic [63:0] adj_rows [64];
    logic [6:0]  vcount;
    out_item_t   pending_bridges [$];
    int          mismatches;
    int          finds;
    int          checked;
    // search scratch state
    logic [63:0] seen;
    int          disc [64];
    int          lowl [64];
    int          par [64];
    int          stk_v [64];
    int          stk_i [64];
    int          sp;
    int          tcount;

    function new();
      foreach (adj_rows[i]) adj_rows[i] = '0;
      vcount = 7'd64;
      mismatches = 0;
      finds = 0;
      checked = 0;
    endfunction

    task report(string msg);
      $display("bridge result %0d: %s", checked, msg);
      mismatches++;
    endtask

    function void enter_vertex(int v, int p);
      seen[v] = 1'b1;
      tcount = (tcount + 1) & 127;
      disc[v] = tcount;
      lowl[v] = tcount;
      par[v] = p;
      if (sp < 64) begin
        stk_v[sp] = v;
        stk_i[sp] = 0;
        sp++;
      end
    endfunction

    // depth-first bridge search over the vertices in use
    function void search_bridges();
      int n, u, w, p, cnt;
      logic [63:0] in_use, row;
      out_item_t r;
      n = (vcount > 64) ? 64 : vcount;
      in_use = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
      seen = '0;
      tcount = 0;
      sp = 0;
      cnt = 0;
      for (int root = 0; root < n; root++) begin
        if (seen[root]) continue;
        enter_vertex(root, int'(NO_PARENT));
        while (sp > 0) begin
          u = stk_v[sp-1];
          row = adj_rows[u] & in_use;
          w = 64;
          for (int k = stk_i[sp-1]; k < 64; k++) begin
            if (row[k]) begin
              w = k;
              break;
            end
          end
          if (w < 64) begin
            stk_i[sp-1] = w + 1;
            if (!seen[w]) enter_vertex(w, u);
            else if (w != par[u] && disc[w] < lowl[u]) lowl[u] = disc[w];
          end else begin
            sp--;
            if (sp > 0) begin
              p = stk_v[sp-1];
              if (lowl[u] < lowl[p]) lowl[p] = lowl[u];
              if (lowl[u] > disc[p] && cnt < 63) begin
                r.bridge_parent = p[5:0];
                r.bridge_child = u[5:0];
                r.is_bridge = 1'b1;
                r.last = 1'b0;
                pending_bridges.insert(pending_bridges.size(), r);
                cnt++;
              end
            end
          end
        end
      end
      if (cnt == 0) begin
        r = '0;
        r.last = 1'b1;
        pending_bridges.insert(pending_bridges.size(), r);
      end else begin
        pending_bridges[$].last = 1'b1;
      end
    endfunction

    function void note_item(in_item_t it);
      case (it.mode)
        MODE_ADD: begin
          if (it.end_a != it.end_b) begin
            adj_rows[it.end_a][it.end_b] = 1'b1;
            adj_rows[it.end_b][it.end_a] = 1'b1;
          end
        end
        MODE_REMOVE: begin
          adj_rows[it.end_a][it.end_b] = 1'b0;
          adj_rows[it.end_b][it.end_a] = 1'b0;
        end
        MODE_CLEAR: foreach (adj_rows[i]) adj_rows[i] = '0;
        default: begin
          finds++;
          search_bridges();
        end
      endcase
    endfunction

    task check_result(out_item_t got);
      out_item_t want;
      checked++;
      if (pending_bridges.size() == 0) begin
        report("unexpected item");
      end else begin
        want = pending_bridges.pop_front();
        if (got.bridge_parent !== want.bridge_parent)
          report($sformatf("bridge_parent got %0d expected %0d",
                           got.bridge_parent, want.bridge_parent));
        if (got.bridge_child !== want.bridge_child)
          report($sformatf("bridge_child got %0d expected %0d",
                           got.bridge_child, want.bridge_child));
        if (got.is_bridge !== want.is_bridge)
          report($sformatf("is_bridge got %0d expected %0d",
                           got.is_bridge, want.is_bridge));
        if (got.last !== want.last)
          report($sformatf("last got %0d expected %0d", got.last, want.last));
      end
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  in_item_t   in_item = '0;
  logic       in_stall;
  logic       out_valid;
  logic       out_stall = 1'b1;
  out_item_t  out_item;
  logic       cfg_wr_en = 1'b0;
  logic [6:0] cfg_wr_data = 7'd64;

  bridge_scoreboard sb = new();
  bit hold_req = 1'b0;
  int sent = 0;
  int send_run = 0;

  graph_bridge_finder_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_item    (in_item),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  // offer one item after a random gap and wait until it is taken
  task send_item(logic [1:0] m, int a, int b);
    int gap;
    in_item_t it;
    it.mode = m;
    it.end_a = a[5:0];
    it.end_b = b[5:0];
    if (send_run > 0) begin
      gap = 0;
      send_run--;
    end else begin
      gap = $urandom_range(0, 9);
      if ($urandom_range(0, 19) == 0) send_run = 12;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
    sb.note_item(it);
    sent++;
  endtask

  // let the block drain, then write the vertex count
  task set_vertex_count(int v);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_bridges.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v[6:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.vcount = v[6:0];
  endtask

  // random traffic mostly on vertices in use, now and then anywhere
  task random_items(int count, int vc);
    int a, b, sel;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 99);
      if ($urandom_range(0, 9) == 0) begin
        a = $urandom_range(0, 63);
        b = $urandom_range(0, 63);
      end else begin
        a = $urandom_range(0, vc - 1);
        b = $urandom_range(0, vc - 1);
      end
      if (sel < 58) send_item(MODE_ADD, a, b);
      else if (sel < 80) send_item(MODE_REMOVE, a, b);
      else if (sel < 83) send_item(MODE_CLEAR, a, b);
      else send_item(MODE_FIND, a, b);
    end
  endtask

  // result side stall pattern, with one long hold on request
  initial begin
    int g;
    int recv_run;
    recv_run = 0;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        g = 400;
        hold_req = 1'b0;
      end else if (recv_run > 0) begin
        g = 0;
        recv_run--;
      end else begin
        g = $urandom_range(0, 9);
        if ($urandom_range(0, 19) == 0) recv_run = 15;
      end
      if (g > 0) begin
        out_stall <= 1'b1;
        repeat (g) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_item);
  end

  // stimulus
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: empty graph, extremes, self-loop, repeats, removals, clear
    send_item(MODE_FIND, 63, 63);
    send_item(MODE_ADD, 0, 63);
    send_item(MODE_ADD, 63, 0);
    send_item(MODE_ADD, 5, 5);
    send_item(MODE_FIND, 0, 0);
    send_item(MODE_ADD, 1, 2);
    send_item(MODE_ADD, 2, 3);
    send_item(MODE_ADD, 3, 1);
    send_item(MODE_ADD, 3, 4);
    send_item(MODE_ADD, 42, 21);
    send_item(MODE_REMOVE, 7, 9);
    send_item(MODE_FIND, 0, 0);
    send_item(MODE_REMOVE, 63, 0);
    send_item(MODE_FIND, 0, 0);
    send_item(MODE_CLEAR, 63, 63);
    send_item(MODE_FIND, 0, 0);
    // smallest size, stored edges above the used range
    set_vertex_count(2);
    send_item(MODE_FIND, 0, 0);
    send_item(MODE_ADD, 0, 1);
    send_item(MODE_ADD, 1, 40);
    send_item(MODE_FIND, 0, 0);
    random_items(30, 2);
    set_vertex_count(8);
    random_items(20, 8);
    hold_req = 1'b1;
    random_items(50, 8);
    set_vertex_count(16);
    random_items(100, 16);
    set_vertex_count(5);
    random_items(50, 5);
    // full size, scattered single edges plus random edges
    set_vertex_count(64);
    for (int i = 0; i < 63; i += 9) send_item(MODE_ADD, i, i + 1);
    random_items(40, 64);
    send_item(MODE_FIND, 0, 0);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_bridges.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("sent %0d items with %0d finds over vertex counts 64, 2, 8, 16, 5, 64",
             sent, sb.finds);
    $display("checked %0d bridge results, %0d mismatches", sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_bridges.size() == 0) begin
      $display("graph_bridge_finder_unit: match");
    end else begin
      $display("graph_bridge_finder_unit: mismatch");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("graph_bridge_finder_unit: mismatch");
    $finish;
  end

endmodule
